@@ rtl/pklpm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Pointer map package
// Types, codes and constants that the front, the back and the top level share.
// ----------------------------------------------------------------------------
package pklpm_pkg;

  localparam int unsigned DefTableDepth = 1024;
  localparam int unsigned KeyW = 64;
  localparam int unsigned HandleW = 64;
  localparam int unsigned OpW = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned HomeShift = 3;

  localparam logic [KeyW-1:0] KeyEmpty = 64'd0;
  localparam logic [KeyW-1:0] KeyTomb = 64'd1;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_NEW      = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_MISS     = 3'd3,
    ST_FULL     = 3'd4,
    ST_INVALID  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PROBE,
    BK_RESOLVE
  } back_state_e;

  typedef struct packed {
    logic               ok;
    logic [OpW-1:0]     opcode;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage
`default_nettype wire

@@ rtl/pklpm_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Pointer map front end
// Accepts commands, flags reserved keys and unused opcodes, and holds them in
// a two-entry queue until the back end takes them.
// ----------------------------------------------------------------------------
module pklpm_front
  import pklpm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [OpW-1:0]     opcode_i,
  input  wire logic [KeyW-1:0]    key_i,
  input  wire logic [HandleW-1:0] handle_i,
  input  wire logic               clearing_i,
  input  wire logic               pop_i,
  output      logic               busy_o,
  output      queue_head_t        head_o
);

  cmd_t       ent_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.ok = (key_i != KeyEmpty) && (key_i != KeyTomb) &&
                ((opcode_i == OP_INSERT) || (opcode_i == OP_LOOKUP) ||
                 (opcode_i == OP_REMOVE));
    cmd_in.opcode = opcode_i;
    cmd_in.key = key_i;
    cmd_in.handle = handle_i;
  end

  assign busy_o = (cnt_q == 2'd2) || clearing_i;
  assign push = start_i && !busy_o;

  always_comb begin
    wr_d = push ? !wr_q : wr_q;
    rd_d = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= cmd_in;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd = ent_q[rd_q];

endmodule
`default_nettype wire

@@ rtl/pklpm_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Pointer map back end
// Clears the key store after reset, walks probe chains one slot per cycle and
// applies inserts, updates and removes to the key and handle stores.
// ----------------------------------------------------------------------------
module pklpm_back
  import pklpm_pkg::*;
#(
  parameter int unsigned TableDepth = DefTableDepth,
  localparam int unsigned SlotW = $clog2(TableDepth),
  localparam int unsigned CntW = $clog2(TableDepth + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire queue_head_t        head_i,
  output      logic               pop_o,
  output      logic               clearing_o,
  output      logic               result_valid_o,
  output      logic [StatusW-1:0] status_o,
  output      logic [HandleW-1:0] found_handle_o,
  output      logic [SlotW-1:0]   slot_o,
  output      logic [CntW-1:0]    live_entries_o
);

  localparam logic [SlotW-1:0] LastSlot = SlotW'(TableDepth - 1);
  localparam logic [CntW:0] FullMark = (CntW + 1)'(TableDepth - 1);

  logic [KeyW-1:0]    key_mem [TableDepth];
  logic [HandleW-1:0] hdl_mem [TableDepth];
  logic [KeyW-1:0]    rd_key_q;
  logic [HandleW-1:0] rd_hdl_q;

  back_state_e state_q, state_d;
  cmd_t             cmd_q;
  logic [SlotW-1:0] cur_q, addr_q, cnt_q, clr_q;
  logic             hit_v_q, tomb_v_q, empty_v_q;
  logic [SlotW-1:0] hit_slot_q, tomb_slot_q, empty_slot_q;
  logic [HandleW-1:0] fh_q;
  logic [CntW-1:0]  live_q, live_d, popc_q, popc_d;

  logic               res_valid_q;
  status_e            res_status_q, res_status_d;
  logic [HandleW-1:0] res_fh_q, res_fh_d;
  logic [SlotW-1:0]   res_slot_q, res_slot_d;

  logic [SlotW-1:0]   rd_addr, home;
  logic               k_empty, k_hit, k_tomb, probe_end, full, is_ins;
  logic               kwe, hwe;
  logic [SlotW-1:0]   kwa, hwa;
  logic [KeyW-1:0]    kwd;
  logic [HandleW-1:0] hwd;

  assign home = head_i.cmd.key[SlotW+HomeShift-1:HomeShift];
  assign k_empty = (rd_key_q == KeyEmpty);
  assign k_hit = (rd_key_q == cmd_q.key);
  assign k_tomb = (rd_key_q == KeyTomb);
  assign probe_end = k_empty || k_hit || (cnt_q == LastSlot);
  assign full = ({popc_q, 1'b0} >= FullMark);
  assign is_ins = (cmd_q.opcode == OP_INSERT);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CLEAR: begin
        if (clr_q == LastSlot) state_d = BK_IDLE;
      end
      BK_IDLE: begin
        if (head_i.valid && head_i.cmd.ok) state_d = BK_PROBE;
      end
      BK_PROBE: begin
        if (probe_end) state_d = BK_RESOLVE;
      end
      BK_RESOLVE: begin
        state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    clearing_o = 1'b0;
    rd_addr = addr_q;
    kwe = 1'b0;
    kwa = hit_slot_q;
    kwd = cmd_q.key;
    hwe = 1'b0;
    hwa = hit_slot_q;
    hwd = cmd_q.handle;
    live_d = live_q;
    popc_d = popc_q;
    res_status_d = ST_INVALID;
    res_fh_d = '0;
    res_slot_d = '0;
    unique case (state_q)
      BK_CLEAR: begin
        clearing_o = 1'b1;
        kwe = 1'b1;
        kwa = clr_q;
        kwd = KeyEmpty;
      end
      BK_IDLE: begin
        pop_o = head_i.valid;
        rd_addr = home;
      end
      BK_PROBE: begin
        rd_addr = addr_q;
      end
      BK_RESOLVE: begin
        if (is_ins) begin
          priority if (hit_v_q) begin
            hwe = 1'b1;
            res_status_d = ST_UPDATED;
            res_slot_d = hit_slot_q;
          end else if (full) begin
            res_status_d = ST_FULL;
          end else if (tomb_v_q) begin
            kwe = 1'b1;
            kwa = tomb_slot_q;
            hwe = 1'b1;
            hwa = tomb_slot_q;
            live_d = live_q + CntW'(1);
            res_status_d = ST_NEW;
            res_slot_d = tomb_slot_q;
          end else if (empty_v_q) begin
            kwe = 1'b1;
            kwa = empty_slot_q;
            hwe = 1'b1;
            hwa = empty_slot_q;
            live_d = live_q + CntW'(1);
            popc_d = popc_q + CntW'(1);
            res_status_d = ST_NEW;
            res_slot_d = empty_slot_q;
          end else begin
            res_status_d = ST_FULL;
          end
        end else if (hit_v_q) begin
          res_status_d = ST_FOUND;
          res_fh_d = fh_q;
          res_slot_d = hit_slot_q;
          if (cmd_q.opcode == OP_REMOVE) begin
            kwe = 1'b1;
            kwd = KeyTomb;
            if (live_q != '0) live_d = live_q - CntW'(1);
          end
        end else begin
          res_status_d = ST_MISS;
        end
      end
      default: begin
        rd_addr = addr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR;
      clr_q <= '0;
      live_q <= '0;
      popc_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      live_q <= live_d;
      popc_q <= popc_d;
      res_valid_q <= 1'b0;
      if (state_q == BK_CLEAR) clr_q <= clr_q + SlotW'(1);
      if ((state_q == BK_RESOLVE) ||
          ((state_q == BK_IDLE) && head_i.valid && !head_i.cmd.ok)) begin
        res_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_fh_q <= res_fh_d;
    res_slot_q <= res_slot_d;
    if ((state_q == BK_IDLE) && head_i.valid) begin
      cmd_q <= head_i.cmd;
      cur_q <= home;
      addr_q <= home + SlotW'(1);
      cnt_q <= '0;
      hit_v_q <= 1'b0;
      tomb_v_q <= 1'b0;
      empty_v_q <= 1'b0;
    end else if (state_q == BK_PROBE) begin
      cur_q <= addr_q;
      addr_q <= addr_q + SlotW'(1);
      cnt_q <= cnt_q + SlotW'(1);
      if (k_empty) begin
        empty_v_q <= 1'b1;
        empty_slot_q <= cur_q;
      end
      if (k_hit) begin
        hit_v_q <= 1'b1;
        hit_slot_q <= cur_q;
        fh_q <= rd_hdl_q;
      end
      if (k_tomb && !tomb_v_q) begin
        tomb_v_q <= 1'b1;
        tomb_slot_q <= cur_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (kwe) key_mem[kwa] <= kwd;
    rd_key_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (hwe) hdl_mem[hwa] <= hwd;
    rd_hdl_q <= hdl_mem[rd_addr];
  end

  assign result_valid_o = res_valid_q;
  assign status_o = res_status_q;
  assign found_handle_o = res_fh_q;
  assign slot_o = res_slot_q;
  assign live_entries_o = live_q;

endmodule
`default_nettype wire

@@ rtl/pointer_keyed_linear_probe_map_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Pointer-keyed linear probe map
// Open-addressing map from 64-bit pointer keys to 64-bit handles with linear
// probing, tombstones on remove and a full mark at half load.
//
//   Channel   Handshake                  Payload
//   command   start_i / busy_o           opcode_i, key_i, handle_i
//   result    result_valid_o (strobe)    status_o, found_handle_o, slot_o,
//                                        live_entries_o
//
// The back end probes a valid command's slots one per cycle through the key
// store read port, at most TABLE_DEPTH of them. A rejected command gives its
// result in the cycle after it leaves the queue. After reset the key store is
// cleared one slot per cycle, with busy_o held high throughout. A two-entry
// queue lets commands be accepted while the back end probes; busy_o rises when
// it is full. Results are shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module pointer_keyed_linear_probe_map_top
  import pklpm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  localparam int unsigned SlotW = $clog2(TABLE_DEPTH),
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output      logic               busy_o,
  input  wire logic [OpW-1:0]     opcode_i,
  input  wire logic [KeyW-1:0]    key_i,
  input  wire logic [HandleW-1:0] handle_i,
  output      logic               result_valid_o,
  output      logic [StatusW-1:0] status_o,
  output      logic [HandleW-1:0] found_handle_o,
  output      logic [SlotW-1:0]   slot_o,
  output      logic [CntW-1:0]    live_entries_o
);

  queue_head_t head;
  logic        pop;
  logic        clearing;

  pklpm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .opcode_i   (opcode_i),
    .key_i      (key_i),
    .handle_i   (handle_i),
    .clearing_i (clearing),
    .pop_i      (pop),
    .busy_o     (busy_o),
    .head_o     (head)
  );

  pklpm_back #(
    .TableDepth (TABLE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .found_handle_o (found_handle_o),
    .slot_o         (slot_o),
    .live_entries_o (live_entries_o)
  );

`ifndef NO_ASSERTIONS
  a_no_result_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    clearing |=> !result_valid_o
  ) else $error("result strobed during the clearing pass");

  a_no_pop_when_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid && !clearing
  ) else $error("queue popped while empty or clearing");

  a_miss_fields_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && ((status_o == ST_MISS) || (status_o == ST_FULL) ||
                       (status_o == ST_INVALID))
    |-> (found_handle_o == '0) && (slot_o == '0)
  ) else $error("miss, full or invalid item carries a handle or slot");

  a_new_raises_live: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == ST_NEW) |-> live_entries_o != '0
  ) else $error("new entry inserted but live count is zero");
`endif

endmodule
`default_nettype wire

@@ tb/pointer_keyed_linear_probe_map_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pointer-keyed linear probe map testbench
// Drives insert, lookup and remove commands through the start/busy handshake
// and checks every result strobe against a shadow copy of the map. A table of
// directed commands covers reserved keys, the unused opcode, wrap at the top
// of the table, tombstone reuse and updates behind a tombstone. Random traffic
// then works a clustered key pool, fills the table up to the full mark and
// keeps going once inserts of new keys are refused.
// ----------------------------------------------------------------------------
module pointer_keyed_linear_probe_map_top_tb;
  import pklpm_pkg::*;

  localparam int unsigned TableDepth = DefTableDepth;
  localparam int unsigned SlotW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned QuietLimit = 8 * (TableDepth + 16);
  localparam int unsigned PoolSize = 48;
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [HandleW-1:0] found_handle;
    logic [SlotW-1:0]   slot;
    logic [CntW-1:0]    live;
  } map_result_t;

  typedef struct {
    logic [OpW-1:0]     op;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] hdl;
    bit                 typed;
    map_result_t        want;
  } cmd_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [OpW-1:0]     opcode_i;
  logic [KeyW-1:0]    key_i;
  logic [HandleW-1:0] handle_i;
  logic               result_valid_o;
  logic [StatusW-1:0] status_o;
  logic [HandleW-1:0] found_handle_o;
  logic [SlotW-1:0]   slot_o;
  logic [CntW-1:0]    live_entries_o;

  logic [KeyW-1:0]    shadow_keys [TableDepth];
  logic [HandleW-1:0] shadow_handles [TableDepth];
  int unsigned        shadow_live;
  int unsigned        shadow_populated;

  map_result_t        pending_results [$];
  cmd_row_t           directed_rows [$];
  logic [KeyW-1:0]    pool_keys [PoolSize];
  logic [KeyW-1:0]    fresh_keys [$];
  int unsigned        fail_count = 0;
  int unsigned        quiet_cycles = 0;

  pointer_keyed_linear_probe_map_top #(
    .TABLE_DEPTH(TableDepth)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .key_i         (key_i),
    .handle_i      (handle_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .found_handle_o(found_handle_o),
    .slot_o        (slot_o),
    .live_entries_o(live_entries_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow map: applies one command and returns the result it should give.
  function automatic map_result_t apply_map_op(input logic [OpW-1:0] op,
                                               input logic [KeyW-1:0] key,
                                               input logic [HandleW-1:0] hdl);
    map_result_t r;
    int hit;
    int tomb;
    int free_slot;
    int unsigned s;
    r = '0;
    r.status = ST_INVALID;
    if (key != KeyEmpty && key != KeyTomb && op != OpUnused) begin
      hit = -1;
      tomb = -1;
      free_slot = -1;
      s = int'(key[HomeShift +: SlotW]);
      for (int n = 0; n < int'(TableDepth); n++) begin
        if (shadow_keys[s] == KeyEmpty) begin
          free_slot = int'(s);
          break;
        end
        if (shadow_keys[s] == key) begin
          hit = int'(s);
          break;
        end
        if (shadow_keys[s] == KeyTomb && tomb < 0) tomb = int'(s);
        s = (s + 1) % TableDepth;
      end
      if (op == OP_INSERT) begin
        if (hit >= 0) begin
          shadow_handles[hit] = hdl;
          r.status = ST_UPDATED;
          r.slot = SlotW'(hit);
        end else if (2 * shadow_populated >= TableDepth - 1) begin
          r.status = ST_FULL;
        end else if (tomb >= 0) begin
          shadow_keys[tomb] = key;
          shadow_handles[tomb] = hdl;
          shadow_live++;
          r.status = ST_NEW;
          r.slot = SlotW'(tomb);
        end else if (free_slot >= 0) begin
          shadow_keys[free_slot] = key;
          shadow_handles[free_slot] = hdl;
          shadow_live++;
          shadow_populated++;
          r.status = ST_NEW;
          r.slot = SlotW'(free_slot);
        end else begin
          r.status = ST_FULL;
        end
      end else if (hit >= 0) begin
        r.found_handle = shadow_handles[hit];
        r.slot = SlotW'(hit);
        r.status = ST_FOUND;
        if (op == OP_REMOVE) begin
          shadow_keys[hit] = KeyTomb;
          if (shadow_live > 0) shadow_live--;
        end
      end else begin
        r.status = ST_MISS;
      end
    end
    r.live = CntW'(shadow_live);
    return r;
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) < pct) return int'($urandom_range(1, 12));
    return 0;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  function automatic logic [KeyW-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  task automatic add_row(input logic [OpW-1:0] op, input logic [KeyW-1:0] key,
                         input logic [HandleW-1:0] hdl, input bit typed,
                         input logic [StatusW-1:0] st, input logic [HandleW-1:0] fh,
                         input int slot, input int live);
    cmd_row_t row;
    row.op = op;
    row.key = key;
    row.hdl = hdl;
    row.typed = typed;
    row.want.status = st;
    row.want.found_handle = fh;
    row.want.slot = SlotW'(slot);
    row.want.live = CntW'(live);
    directed_rows.push_back(row);
  endtask

  // Idles for the gap, presents the item and holds it until it is taken.
  task automatic send_cmd(input logic [OpW-1:0] op, input logic [KeyW-1:0] key,
                          input logic [HandleW-1:0] hdl, input int gap,
                          input bit typed, input map_result_t want);
    map_result_t r;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    key_i <= key;
    handle_i <= hdl;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    r = apply_map_op(op, key, hdl);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic send_pool_cmd(input int gap);
    logic [KeyW-1:0] key;
    int unsigned pick;
    key = pool_keys[$urandom_range(0, PoolSize - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 40) send_cmd(OP_INSERT, key, random_word(), gap, 1'b0, '0);
    else if (pick < 70) send_cmd(OP_LOOKUP, key, random_word(), gap, 1'b0, '0);
    else if (pick < 92) send_cmd(OP_REMOVE, key, random_word(), gap, 1'b0, '0);
    else if (pick < 96) begin
      send_cmd(OpW'($urandom_range(0, 3)), KeyW'($urandom_range(0, 1)), random_word(),
               gap, 1'b0, '0);
    end else send_cmd(OpUnused, key, random_word(), gap, 1'b0, '0);
  endtask

  task automatic send_fill_cmd(input int gap);
    logic [KeyW-1:0] key;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70 || fresh_keys.size() == 0) begin
      key = random_word();
      if (key < 2) key[40] = 1'b1;
      fresh_keys.push_back(key);
      send_cmd(OP_INSERT, key, random_word(), gap, 1'b0, '0);
    end else if (pick < 82) begin
      key = fresh_keys[$urandom_range(0, fresh_keys.size() - 1)];
      send_cmd(OP_LOOKUP, key, random_word(), gap, 1'b0, '0);
    end else if (pick < 88) begin
      key = fresh_keys[$urandom_range(0, fresh_keys.size() - 1)];
      send_cmd(OP_INSERT, key, random_word(), gap, 1'b0, '0);
    end else if (pick < 95) begin
      key = fresh_keys[$urandom_range(0, fresh_keys.size() - 1)];
      send_cmd(OP_REMOVE, key, random_word(), gap, 1'b0, '0);
    end else begin
      send_cmd(OP_LOOKUP, random_word() | 64'h2, random_word(), gap, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    map_result_t seen;
    map_result_t want;
    if (rst_ni && result_valid_o) begin
      seen = {status_o, found_handle_o, slot_o, live_entries_o};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("Unexpected result: status %0d handle %h slot %0d live %0d",
                   seen.status, seen.found_handle, seen.slot, seen.live);
        end
      end else begin
        want = pending_results.pop_front();
        if (seen.status !== want.status || seen.found_handle !== want.found_handle ||
            seen.slot !== want.slot || seen.live !== want.live) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Mismatch: expected status %0d handle %h slot %0d live %0d",
                     want.status, want.found_handle, want.slot, want.live);
            $display("          actual   status %0d handle %h slot %0d live %0d",
                     seen.status, seen.found_handle, seen.slot, seen.live);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [KeyW-1:0] ka;
    logic [KeyW-1:0] kb;
    logic [KeyW-1:0] kc;
    logic [KeyW-1:0] kd;
    logic [KeyW-1:0] ke;
    logic [KeyW-1:0] ones;
    logic [KeyW-1:0] key;
    int idle_pct;
    int fill_items;
    rst_ni = 1'b0;
    start_i = 1'b0;
    opcode_i = '0;
    key_i = '0;
    handle_i = '0;
    for (int i = 0; i < int'(TableDepth); i++) begin
      shadow_keys[i] = KeyEmpty;
      shadow_handles[i] = '0;
    end
    shadow_live = 0;
    shadow_populated = 0;

    // The pool crowds a few home slots, two of them at the top of the table.
    for (int i = 0; i < int'(PoolSize); i++) begin
      key = random_word();
      case (i % 6)
        0: key[HomeShift +: SlotW] = SlotW'(TableDepth - 2);
        1: key[HomeShift +: SlotW] = SlotW'(TableDepth - 1);
        2: key[HomeShift +: SlotW] = '0;
        3: key[HomeShift +: SlotW] = SlotW'(5);
        4: key[HomeShift +: SlotW] = SlotW'(TableDepth / 2 + 5);
        default: key[HomeShift +: SlotW] = SlotW'($urandom_range(0, TableDepth - 1));
      endcase
      if (key < 2) key[40] = 1'b1;
      pool_keys[i] = key;
    end

    ones = '1;
    ka = 64'hFFFF_FFFF_FFFF_FFFF;
    kb = 64'hFFFF_FFFF_FFFF_FFF8;
    kc = 64'h0000_0000_0000_0002;
    kd = 64'h8000_0000_0000_1FF8;
    ke = 64'h0000_0000_0000_0003;
    add_row(OP_LOOKUP, 64'h1000, '0, 1'b1, ST_MISS, '0, 0, 0);
    add_row(OP_REMOVE, 64'h1000, '0, 1'b1, ST_MISS, '0, 0, 0);
    add_row(OP_INSERT, KeyEmpty, ones, 1'b1, ST_INVALID, '0, 0, 0);
    add_row(OP_LOOKUP, KeyTomb, '0, 1'b1, ST_INVALID, '0, 0, 0);
    add_row(OP_REMOVE, KeyEmpty, '0, 1'b1, ST_INVALID, '0, 0, 0);
    add_row(OpUnused, 64'h2000, ones, 1'b1, ST_INVALID, '0, 0, 0);
    add_row(OP_INSERT, ka, ones, 1'b1, ST_NEW, '0, TableDepth - 1, 1);
    add_row(OP_LOOKUP, ka, '0, 1'b1, ST_FOUND, ones, TableDepth - 1, 1);
    add_row(OP_INSERT, kb, '0, 1'b0, ST_NEW, '0, 0, 0);
    add_row(OP_INSERT, kc, 64'h5555_5555_5555_5555, 1'b0, ST_NEW, '0, 0, 0);
    add_row(OP_INSERT, ka, 64'h0123_4567_89AB_CDEF, 1'b0, ST_NEW, '0, 0, 0);
    add_row(OP_REMOVE, ka, '0, 1'b0, ST_NEW, '0, 0, 0);
    add_row(OP_LOOKUP, kb, '0, 1'b0, ST_NEW, '0, 0, 0);
    add_row(OP_INSERT, kd, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, ST_NEW, '0, 0, 0);
    add_row(OP_REMOVE, kb, '0, 1'b0, ST_NEW, '0, 0, 0);
    add_row(OP_INSERT, kb, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0, ST_NEW, '0, 0, 0);
    add_row(OP_REMOVE, kc, '0, 1'b0, ST_NEW, '0, 0, 0);
    add_row(OP_REMOVE, kc, '0, 1'b0, ST_NEW, '0, 0, 0);
    add_row(OP_LOOKUP, kc, '0, 1'b0, ST_NEW, '0, 0, 0);
    add_row(OP_INSERT, ke, '0, 1'b0, ST_NEW, '0, 0, 0);
    add_row(OP_REMOVE, kd, '0, 1'b0, ST_NEW, '0, 0, 0);
    add_row(OP_INSERT, kb, 64'h1, 1'b0, ST_NEW, '0, 0, 0);
    add_row(OP_INSERT, KeyTomb, ones, 1'b0, ST_NEW, '0, 0, 0);
    add_row(OP_LOOKUP, ka, '0, 1'b0, ST_NEW, '0, 0, 0);
    add_row(OpUnused, kb, '0, 1'b0, ST_NEW, '0, 0, 0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].op, directed_rows[i].key, directed_rows[i].hdl,
               pick_gap(30), directed_rows[i].typed, directed_rows[i].want);
    end

    idle_pct = 0;
    for (int i = 0; i < 560; i++) begin
      if (i % 64 == 0) idle_pct = pick_idle_pct();
      send_pool_cmd(pick_gap(idle_pct));
    end

    // Fill the table to the full mark, then keep pushing new keys at it.
    fill_items = 0;
    while (2 * shadow_populated < TableDepth - 1 && fill_items < 900) begin
      if (fill_items % 64 == 0) idle_pct = pick_idle_pct();
      send_fill_cmd(pick_gap(idle_pct));
      fill_items++;
    end
    for (int i = 0; i < 40; i++) send_fill_cmd(pick_gap(idle_pct));

    for (int i = 0; i < 120; i++) begin
      if (i % 2 == 0) send_pool_cmd(0);
      else send_fill_cmd(0);
    end

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TableDepth + 4) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pklpm_pkg.sv
rtl/pklpm_front.sv
rtl/pklpm_back.sv
rtl/pointer_keyed_linear_probe_map_top.sv
tb/pointer_keyed_linear_probe_map_top_tb.sv
